// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies; expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion clocked on clk, off during reset
`define FLP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define FLP_ASSERT_IMPLY(label, ante, cons, msg) \
	`FLP_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define FLP_ASSERT_NEXT(label, ante, cons, msg) \
	`FLP_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- hw/rtl/flp_pkg.sv -----
// shared types, constants and codes of the flow layout row packer
// no dependencies
package flp_pkg;

	localparam int ROW_DEPTH_DEF = 16;

	localparam int DIM_W  = 20;
	localparam int POSX_W = 22;
	localparam int POSY_W = 32;
	localparam int NEED_W = 22;
	localparam int ALU_W  = 34;
	localparam int CFG_IDX_W = 2;

	localparam logic [DIM_W-1:0] ONE_FX = 20'd16;
	localparam logic [DIM_W-1:0] AVAIL_RESET = 20'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_MODE  = 2'd2;

	localparam logic [1:0] ALIGN_LEFT   = 2'd0;
	localparam logic [1:0] ALIGN_RIGHT  = 2'd1;
	localparam logic [1:0] ALIGN_CENTER = 2'd2;

	typedef enum logic [1:0] {
		ALU_ADD3,
		ALU_SUB,
		ALU_SAT_ADD
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} alu_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_APPEND,
		ST_ROW_START,
		ST_ROW_BOTTOM,
		ST_READ,
		ST_EMIT,
		ST_ROW_END
	} state_t;

endpackage

// ----- hw/rtl/flp_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module flp_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/flp_alu.sv -----
// shared add, subtract and saturating add unit of the row packer
// depends on flp_pkg
module flp_alu (
	input  flp_pkg::alu_req_t          req,
	output logic [flp_pkg::ALU_W-1:0]  res
);

	logic [32:0] sat_sum;

	assign sat_sum = {1'b0, req.a} + {1'b0, req.b};

	always_comb begin
		case (req.op)
			flp_pkg::ALU_ADD3: begin
				res = {2'b00, req.a} + {2'b00, req.b} + {2'b00, req.c};
			end
			flp_pkg::ALU_SUB: begin
				res = {2'b00, req.a} - {2'b00, req.b};
			end
			flp_pkg::ALU_SAT_ADD: begin
				res = sat_sum[32] ? {2'b00, 32'hFFFF_FFFF} : {2'b00, sat_sum[31:0]};
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/flow_layout_row_packer_core.sv -----
// greedy line-wrap flow layout in 16.4 fixed point
// Item sizes enter on in_valid/in_ready (item_width, item_height, final_item).
// Positions leave on out_valid/out_ready, one transfer per placed item, with
// last on the final result caused by an input and total_height on the final
// result of a final item. Registers are written on cfg_we (0 avail_width,
// 1 gap, 2 align_mode); the user must write them only while the block is idle
// and the block does not enforce this. A small sequencer drives one shared
// adder/subtractor (flp_alu) and a row buffer ram (flp_ram). An item that fits
// the open row and does not close it passes the check and append steps and
// produces no result. Closing a row steps through the row offset, the row
// bottom, a buffer read and then a position add and emit for each item, and
// the advance of the row top. An item that closes a row before and after
// itself spends both closings. in_ready is high only in the idle state.
// If the receiver stalls, the emit step waits with the result held in the
// output register; no result is dropped.
// After reset the row is empty, the row top is zero, avail_width is 1.0,
// gap and align_mode are zero; the row buffer needs no clearing.
// depends on flp_pkg, flp_alu, flp_ram
module flow_layout_row_packer_core #(
	parameter int ROW_DEPTH = flp_pkg::ROW_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [flp_pkg::DIM_W-1:0]         item_width,
	input  logic [flp_pkg::DIM_W-1:0]         item_height,
	input  logic                              final_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [flp_pkg::POSX_W-1:0] pos_x,
	output logic [flp_pkg::POSY_W-1:0]        pos_y,
	output logic [flp_pkg::POSY_W-1:0]        total_height,
	output logic                              last,
	input  logic                              cfg_we,
	input  logic [flp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [flp_pkg::DIM_W-1:0]         cfg_data
);

	localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
	localparam int CW = $clog2(ROW_DEPTH + 1);

	flp_pkg::state_t state_q, state_d;

	logic [flp_pkg::DIM_W-1:0]  avail_q, gap_q;
	logic [1:0]                 align_q;

	logic [flp_pkg::DIM_W-1:0]  fill_q, tallest_q;
	logic [CW-1:0]              count_q, idx_q;
	logic [flp_pkg::POSY_W-1:0] top_q, bottom_q;
	logic                       close_after_q;

	logic [flp_pkg::DIM_W-1:0]  w_q, h_q;
	logic                       fin_q;
	logic [flp_pkg::NEED_W-1:0] need_q;
	logic [flp_pkg::POSX_W-1:0] x_q;

	logic                       out_valid_q, last_q;
	logic [flp_pkg::POSX_W-1:0] pos_x_q;
	logic [flp_pkg::POSY_W-1:0] pos_y_q, total_q;

	flp_pkg::alu_req_t          alu_req;
	logic [flp_pkg::ALU_W-1:0]  alu_res;
	logic [flp_pkg::DIM_W-1:0]  rd_data;

	logic                       out_free, idx_last, row_close;
	logic signed [20:0]         diff;
	logic [flp_pkg::POSX_W-1:0] x0;

	assign out_free = !out_valid_q || out_ready;
	assign idx_last = (idx_q + CW'(1)) == count_q;
	assign row_close = (count_q != '0) &&
		((count_q == CW'(ROW_DEPTH)) ||
		 (alu_res[flp_pkg::NEED_W-1:0] > {2'b00, avail_q}));

	assign diff = alu_res[20:0];

	always_comb begin
		case (align_q)
			flp_pkg::ALIGN_RIGHT:  x0 = {{1{diff[20]}}, diff};
			flp_pkg::ALIGN_CENTER: x0 = {{2{diff[20]}}, diff[20:1]};
			default:               x0 = '0;
		endcase
	end

	flp_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	flp_ram #(
		.WIDTH (flp_pkg::DIM_W),
		.DEPTH (ROW_DEPTH)
	) u_row_buf (
		.clk   (clk),
		.we    (state_q == flp_pkg::ST_APPEND),
		.waddr (count_q[AW-1:0]),
		.wdata (w_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		alu_req  = '{op: flp_pkg::ALU_ADD3, a: '0, b: '0, c: '0};
		case (state_q)
			flp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = flp_pkg::ST_CHECK;
				end
			end
			flp_pkg::ST_CHECK: begin
				alu_req = '{op: flp_pkg::ALU_ADD3, a: 32'(fill_q), b: 32'(gap_q),
					c: 32'(w_q)};
				state_d = row_close ? flp_pkg::ST_ROW_START : flp_pkg::ST_APPEND;
			end
			flp_pkg::ST_APPEND: begin
				state_d = fin_q ? flp_pkg::ST_ROW_START : flp_pkg::ST_IDLE;
			end
			flp_pkg::ST_ROW_START: begin
				alu_req = '{op: flp_pkg::ALU_SUB, a: 32'(avail_q), b: 32'(fill_q),
					c: '0};
				state_d = flp_pkg::ST_ROW_BOTTOM;
			end
			flp_pkg::ST_ROW_BOTTOM: begin
				alu_req = '{op: flp_pkg::ALU_SAT_ADD, a: top_q, b: 32'(tallest_q),
					c: '0};
				state_d = flp_pkg::ST_READ;
			end
			flp_pkg::ST_READ: begin
				state_d = flp_pkg::ST_EMIT;
			end
			flp_pkg::ST_EMIT: begin
				alu_req = '{op: flp_pkg::ALU_ADD3, a: 32'(x_q), b: 32'(rd_data),
					c: 32'(gap_q)};
				if (out_free) begin
					state_d = idx_last ? flp_pkg::ST_ROW_END : flp_pkg::ST_READ;
				end
			end
			flp_pkg::ST_ROW_END: begin
				alu_req = '{op: flp_pkg::ALU_SAT_ADD, a: bottom_q, b: 32'(gap_q),
					c: '0};
				state_d = close_after_q ? flp_pkg::ST_IDLE : flp_pkg::ST_APPEND;
			end
			default: begin
				state_d = flp_pkg::ST_IDLE;
			end
		endcase
	end

	// control state, config and row bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= flp_pkg::ST_IDLE;
			avail_q       <= flp_pkg::AVAIL_RESET;
			gap_q         <= '0;
			align_q       <= flp_pkg::ALIGN_LEFT;
			fill_q        <= '0;
			tallest_q     <= '0;
			count_q       <= '0;
			idx_q         <= '0;
			top_q         <= '0;
			close_after_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					flp_pkg::CFG_AVAIL_WIDTH: avail_q <= cfg_data;
					flp_pkg::CFG_GAP:         gap_q   <= cfg_data;
					flp_pkg::CFG_ALIGN_MODE:  align_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if ((state_q == flp_pkg::ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				flp_pkg::ST_CHECK: begin
					close_after_q <= 1'b0;
				end
				flp_pkg::ST_APPEND: begin
					fill_q <= (count_q == '0) ? w_q : need_q[flp_pkg::DIM_W-1:0];
					if (h_q > tallest_q) begin
						tallest_q <= h_q;
					end
					count_q       <= count_q + CW'(1);
					close_after_q <= fin_q;
				end
				flp_pkg::ST_ROW_START: begin
					idx_q <= '0;
				end
				flp_pkg::ST_EMIT: begin
					if (out_free) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				flp_pkg::ST_ROW_END: begin
					top_q     <= close_after_q ? '0 : alu_res[flp_pkg::POSY_W-1:0];
					fill_q    <= '0;
					tallest_q <= '0;
					count_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			flp_pkg::ST_IDLE: begin
				if (in_valid) begin
					w_q   <= (item_width < flp_pkg::ONE_FX) ? flp_pkg::ONE_FX : item_width;
					h_q   <= (item_height < flp_pkg::ONE_FX) ? flp_pkg::ONE_FX : item_height;
					fin_q <= final_item;
				end
			end
			flp_pkg::ST_CHECK: begin
				need_q <= alu_res[flp_pkg::NEED_W-1:0];
			end
			flp_pkg::ST_ROW_START: begin
				x_q <= x0;
			end
			flp_pkg::ST_ROW_BOTTOM: begin
				bottom_q <= alu_res[flp_pkg::POSY_W-1:0];
			end
			flp_pkg::ST_EMIT: begin
				if (out_free) begin
					x_q     <= alu_res[flp_pkg::POSX_W-1:0];
					pos_x_q <= x_q;
					pos_y_q <= top_q;
					last_q  <= idx_last && (close_after_q || !fin_q);
					total_q <= (idx_last && close_after_q) ? bottom_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign total_height = total_q;
	assign last         = last_q;

endmodule

// ----- hw/rtl/flp_checker.sv -----
// port-level assertions on the row packer, bound to the top level
// depends on flp_pkg, assert_macros.svh, flow_layout_row_packer_core
`include "assert_macros.svh"

module flp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [flp_pkg::POSX_W-1:0] pos_x,
	input logic [flp_pkg::POSY_W-1:0]        pos_y,
	input logic [flp_pkg::POSY_W-1:0]        total_height,
	input logic                              last
);

	// total height only rides on the closing result of a run
	`FLP_ASSERT_IMPLY(a_total_on_last, out_valid && (total_height != '0), last,
		"total_height set on a result that is not last")

	// one item in flight: no new transfer right after an input transfer
	`FLP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"input ready right after an input transfer")

	// a stalled result holds
	`FLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(pos_x) && $stable(pos_y) && $stable(last) &&
		$stable(total_height),
		"stalled result changed")

endmodule

bind flow_layout_row_packer_core flp_checker u_flp_checker (.*);

// ----- bench/flow_layout_row_packer_core_tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for flow_layout_row_packer_core: a short stimulus table, random layout
// passes over several width/gap/alignment settings, then a steady run with no idling
// depends on flp_pkg and flow_layout_row_packer_core
module flow_layout_row_packer_core_tb;

	localparam int ROW_SLOTS = flp_pkg::ROW_DEPTH_DEF;
	localparam logic [1:0] ALIGN_UNUSED = 2'd3;
	localparam logic [flp_pkg::DIM_W-1:0] DIM_MAX = '1;
	localparam int RIGHT_ROWS_FROM = 4;
	localparam int RANDOM_PHASES = 7;
	localparam int ITEMS_PER_PHASE = 48;
	localparam int DEEP_ROWS = 24;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 300;
	localparam int REPORT_CAP = 100;

	typedef struct packed {
		logic [flp_pkg::POSX_W-1:0] x;
		logic [flp_pkg::POSY_W-1:0] y;
		logic [flp_pkg::POSY_W-1:0] height;
		logic                       last;
	} placement_t;

	typedef struct packed {
		logic [flp_pkg::DIM_W-1:0] w;
		logic [flp_pkg::DIM_W-1:0] h;
		logic                      fin;
		logic                      fixed;
		logic                      fixed_one;
		placement_t                want;
	} drive_row_t;

	localparam placement_t NO_WANT = '0;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [flp_pkg::DIM_W-1:0]         item_width = '0;
	logic [flp_pkg::DIM_W-1:0]         item_height = '0;
	logic                              final_item = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [flp_pkg::POSX_W-1:0] pos_x;
	logic [flp_pkg::POSY_W-1:0]        pos_y;
	logic [flp_pkg::POSY_W-1:0]        total_height;
	logic                              last;
	logic                              cfg_we = 1'b0;
	logic [flp_pkg::CFG_IDX_W-1:0]     cfg_index = flp_pkg::CFG_AVAIL_WIDTH;
	logic [flp_pkg::DIM_W-1:0]         cfg_data = '0;

	// predictor copy of the registers and the open row
	logic [flp_pkg::DIM_W-1:0] cur_avail = flp_pkg::AVAIL_RESET;
	logic [flp_pkg::DIM_W-1:0] cur_gap = '0;
	logic [1:0]                cur_align = flp_pkg::ALIGN_LEFT;
	logic [flp_pkg::DIM_W-1:0] row_widths [ROW_SLOTS];
	longint unsigned           row_fill;
	longint unsigned           row_peak;
	longint unsigned           row_top_y;
	int                        row_items;

	placement_t pending_positions[$];
	placement_t seen_want;
	int         mismatches;
	int         positions_checked;
	int         items_sent;
	int         passes_sent;
	bit         hold_output;
	bit         steady_tail;

	// reset state: avail 1.0, gap 0, left; every row holds one item
	drive_row_t directed_rows [21] = '{
		'{20'd0,    20'd0,      1'b1, 1'b1, 1'b1, '{22'd0, 32'd0, 32'd16, 1'b1}},
		'{DIM_MAX,  20'd15,     1'b0, 1'b1, 1'b0, NO_WANT},
		'{20'd16,   DIM_MAX,    1'b0, 1'b1, 1'b1, '{22'd0, 32'd0, 32'd0, 1'b1}},
		'{20'd17,   20'd20,     1'b1, 1'b0, 1'b0, NO_WANT},
		// full width, right aligned: the seventeenth item overflows the row buffer
		'{20'h3000, 20'd0,      1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'd0,    DIM_MAX,    1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'd1,    20'd16,     1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'd15,   20'd17,     1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'd16,   20'h55555,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'd17,   20'hAAAAA,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h40,   20'd1,      1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h123,  20'h800,    1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h800,  20'd15,     1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h2A,   20'h12345,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h5555, 20'd0,      1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'hAAA,  20'hFFFFE,  1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h10,   20'h40,     1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h7F,   20'h7F,     1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h1F0,  20'h3,      1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h3,    20'h1000,   1'b0, 1'b0, 1'b0, NO_WANT},
		'{20'h999,  20'h21,     1'b1, 1'b0, 1'b0, NO_WANT}
	};

	flow_layout_row_packer_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.item_width   (item_width),
		.item_height  (item_height),
		.final_item   (final_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.total_height (total_height),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned sat32(longint unsigned v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	// places the open row and returns the layout bottom without trailing gap
	function automatic longint unsigned flush_row();
		longint          offset;
		longint          xpos;
		longint unsigned bottom;
		placement_t      p;
		offset = longint'(cur_avail) - longint'(row_fill);
		case (cur_align)
			flp_pkg::ALIGN_RIGHT:  xpos = offset;
			flp_pkg::ALIGN_CENTER: xpos = offset >>> 1;
			default:               xpos = 0;
		endcase
		for (int i = 0; i < row_items; i++) begin
			p.x = xpos[flp_pkg::POSX_W-1:0];
			p.y = row_top_y[flp_pkg::POSY_W-1:0];
			p.height = '0;
			p.last = 1'b0;
			pending_positions.push_back(p);
			xpos = xpos + longint'(row_widths[i]) + longint'(cur_gap);
		end
		bottom = sat32(row_top_y + row_peak);
		row_top_y = sat32(bottom + cur_gap);
		row_fill = 0;
		row_peak = 0;
		row_items = 0;
		return bottom;
	endfunction

	// queues the positions one item releases and returns how many
	function automatic int predict_item(logic [flp_pkg::DIM_W-1:0] w_in,
			logic [flp_pkg::DIM_W-1:0] h_in, logic fin);
		longint unsigned w;
		longint unsigned h;
		longint unsigned total;
		int              before_cnt;
		placement_t      tail;
		before_cnt = pending_positions.size();
		w = (w_in < flp_pkg::ONE_FX) ? flp_pkg::ONE_FX : w_in;
		h = (h_in < flp_pkg::ONE_FX) ? flp_pkg::ONE_FX : h_in;
		if (row_items > 0 && (row_items >= ROW_SLOTS || row_fill + cur_gap + w > cur_avail))
			void'(flush_row());
		row_fill = (row_items == 0) ? w : row_fill + cur_gap + w;
		if (h > row_peak)
			row_peak = h;
		row_widths[row_items] = w[flp_pkg::DIM_W-1:0];
		row_items++;
		if (fin) begin
			total = flush_row();
			tail = pending_positions.pop_back();
			tail.height = total[flp_pkg::POSY_W-1:0];
			pending_positions.push_back(tail);
			row_top_y = 0;
		end
		if (pending_positions.size() > before_cnt) begin
			tail = pending_positions.pop_back();
			tail.last = 1'b1;
			pending_positions.push_back(tail);
		end
		return pending_positions.size() - before_cnt;
	endfunction

	task automatic send_item(input logic [flp_pkg::DIM_W-1:0] w,
			input logic [flp_pkg::DIM_W-1:0] h, input logic fin, output int produced);
		in_valid <= 1'b1;
		item_width <= w;
		item_height <= h;
		final_item <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		produced = predict_item(w, h, fin);
		items_sent++;
		if (fin)
			passes_sent++;
	endtask

	task automatic maybe_idle_sender();
		if (!steady_tail && !hold_output && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_layout(input logic [flp_pkg::DIM_W-1:0] avail,
			input logic [flp_pkg::DIM_W-1:0] spacing, input logic [1:0] align);
		cfg_we <= 1'b1;
		cfg_index <= flp_pkg::CFG_AVAIL_WIDTH;
		cfg_data <= avail;
		@(posedge clk);
		cfg_index <= flp_pkg::CFG_GAP;
		cfg_data <= spacing;
		@(posedge clk);
		cfg_index <= flp_pkg::CFG_ALIGN_MODE;
		cfg_data <= flp_pkg::DIM_W'(align);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_avail = avail;
		cur_gap = spacing;
		cur_align = align;
	endtask

	task automatic compare_field(input string field, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s mismatch at position %0d, expected %0d, actual %0d",
					$time, field, positions_checked, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("%0t: unexpected transfer, expected none, actual x=%0d y=%0d",
						$time, pos_x, pos_y);
			end else begin
				seen_want = pending_positions.pop_front();
				positions_checked++;
				compare_field("pos_x", $signed(seen_want.x), pos_x);
				compare_field("pos_y", seen_want.y, pos_y);
				compare_field("total_height", seen_want.height, total_height);
				compare_field("last", seen_want.last, last);
			end
		end
	end

	always begin
		@(posedge clk);
		if (hold_output) begin
			out_ready <= 1'b0;
			repeat (LONG_HOLD) @(posedge clk);
			hold_output = 1'b0;
			out_ready <= 1'b1;
		end else if (!steady_tail && $urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 24)) @(posedge clk);
		end
	end

	initial begin : stimulus
		drive_row_t                row;
		logic [flp_pkg::DIM_W-1:0] w;
		logic [flp_pkg::DIM_W-1:0] h;
		logic                      fin;
		int                        made;
		int                        pass_left;
		pass_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed_rows); i++) begin
			row = directed_rows[i];
			if (i == RIGHT_ROWS_FROM) begin
				settle_block();
				program_layout(DIM_MAX, '0, flp_pkg::ALIGN_RIGHT);
			end
			send_item(row.w, row.h, row.fin, made);
			if (row.fixed) begin
				repeat (made) void'(pending_positions.pop_back());
				if (row.fixed_one)
					pending_positions.push_back(row.want);
			end
			maybe_idle_sender();
		end

		// open rows carry over into the next setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_block();
			case (phase)
				0: program_layout(DIM_MAX, '0, flp_pkg::ALIGN_CENTER);
				1: program_layout(20'd16, DIM_MAX, flp_pkg::ALIGN_RIGHT);
				2: program_layout('0, flp_pkg::DIM_W'($urandom_range(0, 64)), ALIGN_UNUSED);
				3: program_layout(20'd5, '0, flp_pkg::ALIGN_CENTER);
				default: program_layout(flp_pkg::DIM_W'($urandom_range(16, 'h3000)),
					flp_pkg::DIM_W'($urandom_range(0, 'h80)), 2'($urandom_range(0, 3)));
			endcase
			if (phase == 1)
				hold_output = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (pass_left == 0)
					pass_left = $urandom_range(1, 24);
				pass_left--;
				fin = (pass_left == 0);
				if ($urandom_range(0, 7) == 0)
					fin = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 7))
					0: w = flp_pkg::DIM_W'($urandom_range(0, DIM_MAX));
					1: w = flp_pkg::DIM_W'($urandom_range(0, 40));
					default: w = flp_pkg::DIM_W'($urandom_range(0, cur_avail / 3 + 32));
				endcase
				case ($urandom_range(0, 7))
					0: h = flp_pkg::DIM_W'($urandom_range(0, DIM_MAX));
					1: h = flp_pkg::DIM_W'($urandom_range(0, 20));
					default: h = flp_pkg::DIM_W'($urandom_range(0, 'h400));
				endcase
				send_item(w, h, fin, made);
				maybe_idle_sender();
			end
		end

		// one item per row at full height and spacing, no idling
		settle_block();
		steady_tail = 1'b1;
		program_layout('0, DIM_MAX, 2'($urandom_range(0, 3)));
		for (int n = 0; n < DEEP_ROWS; n++)
			send_item(flp_pkg::DIM_W'($urandom),
				flp_pkg::DIM_W'($urandom_range('hFFF00, DIM_MAX)), n == DEEP_ROWS - 1, made);

		in_valid <= 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d items in %0d layout passes, %0d positions checked",
			items_sent, passes_sent, positions_checked);
		$display("settings: full, tiny and zero widths, all alignments, row overflow, long stall");
		if (mismatches == 0) begin
			$display("PASS flow_layout_row_packer_core");
		end else begin
			$display("FAIL flow_layout_row_packer_core");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("%0t: timed out with %0d positions outstanding", $time,
			pending_positions.size());
		$display("FAIL flow_layout_row_packer_core");
		$finish;
	end

endmodule
